// ===== design/pew_pkg.sv =====
// Shared types, constants and saturation helper for the particle Euler step.
// No dependencies; imported by pew_div, particle_euler_step_with_walls_top and its testbench.
package pew_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_W        = 32;
	localparam int UWORD_W       = 31;
	localparam int DT_W          = 17;
	localparam int CFG_IDX_W     = 3;
	localparam int DIV_STEP_BITS = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DT   = 3'd0,
		REG_GX   = 3'd1,
		REG_GY   = 3'd2,
		REG_MASS = 3'd3,
		REG_RAD  = 3'd4,
		REG_HW   = 3'd5,
		REG_HH   = 3'd6
	} cfg_reg_t;

	localparam logic [DT_W-1:0]           RST_DT   = 17'd655;
	localparam logic signed [WORD_W-1:0]  RST_GX   = 32'sd0;
	localparam logic signed [WORD_W-1:0]  RST_GY   = -32'sd642253;
	localparam logic [UWORD_W-1:0]        RST_MASS = 31'd65536;
	localparam logic [UWORD_W-1:0]        RST_RAD  = 31'd6554;
	localparam logic [UWORD_W-1:0]        RST_HW   = 31'd65536;
	localparam logic [UWORD_W-1:0]        RST_HH   = 31'd65536;

	// Particle word as it moves through the back half of the pipeline.
	typedef struct packed {
		logic signed [WORD_W-1:0] px;
		logic signed [WORD_W-1:0] py;
		logic signed [WORD_W-1:0] vx;
		logic signed [WORD_W-1:0] vy;
		logic signed [WORD_W-1:0] ax;
		logic signed [WORD_W-1:0] ay;
		logic                     zero;
		logic [3:0]               hits;
	} item_t;

	// Clamp a wide signed value to 32-bit signed.
	function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [WORD_W-1:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/pew_div.sv =====
// Pipelined unsigned restoring divider, STEP quotient bits per stage.
// Depends on pew_pkg.
module pew_div import pew_pkg::*; #(
	parameter int NUM_W = 49,
	parameter int DEN_W = UWORD_W,
	parameter int STEP  = DIV_STEP_BITS
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);
	localparam int NS = (NUM_W + STEP - 1) / STEP;
	localparam int PW = NS * STEP;

	logic [PW-1:0]    n_s [NS];
	logic [PW-1:0]    q_s [NS];
	logic [DEN_W-1:0] r_s [NS];
	logic [DEN_W-1:0] d_s [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [PW-1:0]    n_in, q_in, n_nx, q_nx;
		logic [DEN_W-1:0] r_in, d_in, r_nx;

		if (g == 0) begin : g_first
			assign n_in = PW'(num);
			assign q_in = '0;
			assign r_in = '0;
			assign d_in = den;
		end else begin : g_next
			assign n_in = n_s[g-1];
			assign q_in = q_s[g-1];
			assign r_in = r_s[g-1];
			assign d_in = d_s[g-1];
		end

		always_comb begin
			logic [DEN_W:0] trial;
			n_nx = n_in;
			q_nx = q_in;
			r_nx = r_in;
			trial = '0;
			for (int j = 0; j < STEP; j++) begin
				trial = {r_nx, n_nx[PW-1]};
				n_nx  = {n_nx[PW-2:0], 1'b0};
				if (trial >= {1'b0, d_in}) begin
					trial = trial - {1'b0, d_in};
					q_nx  = {q_nx[PW-2:0], 1'b1};
				end else begin
					q_nx  = {q_nx[PW-2:0], 1'b0};
				end
				r_nx = trial[DEN_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			n_s[g] <= n_nx;
			q_s[g] <= q_nx;
			r_s[g] <= r_nx;
			d_s[g] <= d_in;
		end
	end

	assign quo = q_s[NS-1][NUM_W-1:0];

endmodule

// ===== design/particle_euler_step_with_walls_top.sv =====
// Particle Euler step with wall response, fully pipelined top level.
// Depends on pew_pkg and pew_div.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | start, busy          | pos, vel, pressure/viscous/surface force, rho
//  result  | done (strobe)        | new_pos, new_vel, acc, density_was_zero, wall_hits
//  config  | cfg_we, cfg_addr     | cfg_data
//
// One particle word enters per cycle; busy is held low. A word passes the
// stage 1 register, the DIV_STAGES stages of the force/rho divider, which
// resolves DIV_STEP_BITS quotient bits per stage, and then stages 3 to 11.
// Reset loads the config registers with their defaults and clears every valid
// bit; payload is not reset.
// The receiver cannot stall, so the pipeline never holds: done pulses for one
// cycle per accepted word, in order.
module particle_euler_step_with_walls_top import pew_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [WORD_W-1:0]  pos_x,
	input  logic signed [WORD_W-1:0]  pos_y,
	input  logic signed [WORD_W-1:0]  vel_x,
	input  logic signed [WORD_W-1:0]  vel_y,
	input  logic signed [WORD_W-1:0]  pressure_fx,
	input  logic signed [WORD_W-1:0]  pressure_fy,
	input  logic signed [WORD_W-1:0]  viscous_fx,
	input  logic signed [WORD_W-1:0]  viscous_fy,
	input  logic signed [WORD_W-1:0]  surface_fx,
	input  logic signed [WORD_W-1:0]  surface_fy,
	input  logic [UWORD_W-1:0]        rho,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_addr,
	input  logic [WORD_W-1:0]         cfg_data,
	output logic                      done,
	output logic signed [WORD_W-1:0]  new_pos_x,
	output logic signed [WORD_W-1:0]  new_pos_y,
	output logic signed [WORD_W-1:0]  new_vel_x,
	output logic signed [WORD_W-1:0]  new_vel_y,
	output logic signed [WORD_W-1:0]  acc_x,
	output logic signed [WORD_W-1:0]  acc_y,
	output logic                      density_was_zero,
	output logic [3:0]                wall_hits
);
	// Dividend magnitude: |force sum| fits 33 bits, then scaled by 2^FRAC_BITS.
	localparam int     DW          = 33 + FRAC_BITS;
	localparam int     DIV_STAGES  = (DW + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
	localparam int     LAT         = DIV_STAGES + 10;
	localparam longint ONE_FX      = 64'sd1 <<< FRAC_BITS;
	localparam longint RHO_EPS_RAW = (ONE_FX + 5000) / 10000;
	localparam longint RHO_EPS     = (RHO_EPS_RAW > 0) ? RHO_EPS_RAW : 64'sd1;
	localparam int     KW          = FRAC_BITS + 2;
	localparam longint BOUNCE_RAW  = (ONE_FX * 16 + 5) / 10;
	localparam logic [KW-1:0]      BOUNCE_K  = KW'(BOUNCE_RAW);
	localparam logic [UWORD_W-1:0] RHO_EPS_V = UWORD_W'(RHO_EPS);

	typedef struct packed {
		logic signed [WORD_W-1:0] px;
		logic signed [WORD_W-1:0] py;
		logic signed [WORD_W-1:0] vx;
		logic signed [WORD_W-1:0] vy;
		logic signed [WORD_W-1:0] fgx;
		logic signed [WORD_W-1:0] fgy;
		logic                     negx;
		logic                     negy;
		logic                     zero;
	} dly_t;

	// ------------------------------------------------------------------
	// Config registers: the user must write them only while the pipeline is empty; the block does not enforce this.
	// ------------------------------------------------------------------
	logic [DT_W-1:0]          dt_q;
	logic signed [WORD_W-1:0] gx_q, gy_q;
	logic [UWORD_W-1:0]       mass_q, rad_q, hw_q, hh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q   <= RST_DT;
			gx_q   <= RST_GX;
			gy_q   <= RST_GY;
			mass_q <= RST_MASS;
			rad_q  <= RST_RAD;
			hw_q   <= RST_HW;
			hh_q   <= RST_HH;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_DT:   dt_q   <= cfg_data[DT_W-1:0];
				REG_GX:   gx_q   <= cfg_data;
				REG_GY:   gy_q   <= cfg_data;
				REG_MASS: mass_q <= cfg_data[UWORD_W-1:0];
				REG_RAD:  rad_q  <= cfg_data[UWORD_W-1:0];
				REG_HW:   hw_q   <= cfg_data[UWORD_W-1:0];
				REG_HH:   hh_q   <= cfg_data[UWORD_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// Stage 1: force sums, density replacement, mass times gravity product.
	// ------------------------------------------------------------------
	logic                     val_s1;
	logic signed [WORD_W-1:0] px_s1, py_s1, vx_s1, vy_s1;
	logic signed [33:0]       fx_s1, fy_s1;
	logic [UWORD_W-1:0]       rho_s1;
	logic                     zero_s1;
	logic signed [62:0]       mgx_s1, mgy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
		end else begin
			val_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		px_s1   <= pos_x;
		py_s1   <= pos_y;
		vx_s1   <= vel_x;
		vy_s1   <= vel_y;
		fx_s1   <= 34'(pressure_fx) + 34'(viscous_fx) + 34'(surface_fx);
		fy_s1   <= 34'(pressure_fy) + 34'(viscous_fy) + 34'(surface_fy);
		zero_s1 <= (rho == '0);
		rho_s1  <= (rho == '0) ? RHO_EPS_V : rho;
		mgx_s1  <= $signed({1'b0, mass_q}) * gx_q;
		mgy_s1  <= $signed({1'b0, mass_q}) * gy_q;
	end

	// ------------------------------------------------------------------
	// Divider stages: |force sum| * 2^F / rho, side data on a matching line.
	// ------------------------------------------------------------------
	logic [33:0]   absfx, absfy;
	logic [DW-1:0] numx, numy, quox, quoy;
	dly_t          dly_in;

	assign absfx = fx_s1[33] ? 34'(-fx_s1) : 34'(fx_s1);
	assign absfy = fy_s1[33] ? 34'(-fy_s1) : 34'(fy_s1);
	assign numx  = {absfx[32:0], {FRAC_BITS{1'b0}}};
	assign numy  = {absfy[32:0], {FRAC_BITS{1'b0}}};

	pew_div #(.NUM_W(DW), .DEN_W(UWORD_W), .STEP(DIV_STEP_BITS)) u_div_x (
		.clk (clk),
		.num (numx),
		.den (rho_s1),
		.quo (quox)
	);

	pew_div #(.NUM_W(DW), .DEN_W(UWORD_W), .STEP(DIV_STEP_BITS)) u_div_y (
		.clk (clk),
		.num (numy),
		.den (rho_s1),
		.quo (quoy)
	);

	always_comb begin
		dly_in.px   = px_s1;
		dly_in.py   = py_s1;
		dly_in.vx   = vx_s1;
		dly_in.vy   = vy_s1;
		dly_in.fgx  = sat32(64'(mgx_s1 >>> FRAC_BITS));
		dly_in.fgy  = sat32(64'(mgy_s1 >>> FRAC_BITS));
		dly_in.negx = fx_s1[33];
		dly_in.negy = fy_s1[33];
		dly_in.zero = zero_s1;
	end

	dly_t dly_s  [DIV_STAGES];
	logic dval_s [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++) begin
				dval_s[i] <= 1'b0;
			end
		end else begin
			dval_s[0] <= val_s1;
			for (int i = 1; i < DIV_STAGES; i++) begin
				dval_s[i] <= dval_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		dly_s[0] <= dly_in;
		for (int i = 1; i < DIV_STAGES; i++) begin
			dly_s[i] <= dly_s[i-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: signed, saturated quotient plus gravity term -> acceleration.
	// ------------------------------------------------------------------
	dly_t  dl;
	item_t it_s3, it_s4, it_s5, it_s6, it_s7, it_s8, it_s9, it_s10, it_s11;
	item_t it3_d;
	logic  val_s3, val_s4, val_s5, val_s6, val_s7, val_s8, val_s9, val_s10, val_s11;

	assign dl = dly_s[DIV_STAGES-1];

	always_comb begin
		logic signed [63:0]       qx, qy;
		logic signed [WORD_W-1:0] qsx, qsy;
		qx  = dl.negx ? -$signed(64'(quox)) : $signed(64'(quox));
		qy  = dl.negy ? -$signed(64'(quoy)) : $signed(64'(quoy));
		qsx = sat32(qx);
		qsy = sat32(qy);
		it3_d      = '0;
		it3_d.px   = dl.px;
		it3_d.py   = dl.py;
		it3_d.vx   = dl.vx;
		it3_d.vy   = dl.vy;
		it3_d.ax   = sat32(64'(qsx) + 64'(dl.fgx));
		it3_d.ay   = sat32(64'(qsy) + 64'(dl.fgy));
		it3_d.zero = dl.zero;
	end

	// ------------------------------------------------------------------
	// Stages 4-7: velocity then position, product registered before use.
	// ------------------------------------------------------------------
	logic signed [49:0] pvx_s4, pvy_s4, ppx_s6, ppy_s6;
	item_t it5_d, it7_d;

	always_comb begin
		it5_d    = it_s4;
		it5_d.vx = sat32(64'(it_s4.vx) + 64'(sat32(64'(pvx_s4 >>> FRAC_BITS))));
		it5_d.vy = sat32(64'(it_s4.vy) + 64'(sat32(64'(pvy_s4 >>> FRAC_BITS))));
		it7_d    = it_s6;
		it7_d.px = sat32(64'(it_s6.px) + 64'(sat32(64'(ppx_s6 >>> FRAC_BITS))));
		it7_d.py = sat32(64'(it_s6.py) + 64'(sat32(64'(ppy_s6 >>> FRAC_BITS))));
	end

	// ------------------------------------------------------------------
	// Stages 8-11: left/bottom walls, then right/top walls on updated values.
	// ------------------------------------------------------------------
	longint radl, hwl, hhl;
	assign radl = longint'(rad_q);
	assign hwl  = longint'(hw_q);
	assign hhl  = longint'(hh_q);

	logic [WORD_W-1:0]    absvx7, absvy7, absvx9, absvy9;
	logic [WORD_W+KW-1:0] bpx_s8, bpy_s8, bpx_s10, bpy_s10;
	logic                 hx_s8, hy_s8, hx_s10, hy_s10;
	item_t                it9_d, it11_d;

	assign absvx7 = it_s7.vx[WORD_W-1] ? WORD_W'(-it_s7.vx) : WORD_W'(it_s7.vx);
	assign absvy7 = it_s7.vy[WORD_W-1] ? WORD_W'(-it_s7.vy) : WORD_W'(it_s7.vy);
	assign absvx9 = it_s9.vx[WORD_W-1] ? WORD_W'(-it_s9.vx) : WORD_W'(it_s9.vx);
	assign absvy9 = it_s9.vy[WORD_W-1] ? WORD_W'(-it_s9.vy) : WORD_W'(it_s9.vy);

	always_comb begin
		it9_d = it_s8;
		if (hx_s8) begin
			it9_d.vx      = sat32(64'(it_s8.vx) + longint'(bpx_s8 >> FRAC_BITS));
			it9_d.px      = WORD_W'(radl - hwl);
			it9_d.hits[0] = 1'b1;
		end
		if (hy_s8) begin
			it9_d.vy      = sat32(64'(it_s8.vy) + longint'(bpy_s8 >> FRAC_BITS));
			it9_d.py      = WORD_W'(radl - hhl);
			it9_d.hits[2] = 1'b1;
		end
		it11_d = it_s10;
		if (hx_s10) begin
			it11_d.vx      = sat32(64'(it_s10.vx) - longint'(bpx_s10 >> FRAC_BITS));
			it11_d.px      = WORD_W'(hwl - radl);
			it11_d.hits[1] = 1'b1;
		end
		if (hy_s10) begin
			it11_d.vy      = sat32(64'(it_s10.vy) - longint'(bpy_s10 >> FRAC_BITS));
			it11_d.py      = WORD_W'(hhl - radl);
			it11_d.hits[3] = 1'b1;
		end
	end

	// Advance valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s3  <= 1'b0;
			val_s4  <= 1'b0;
			val_s5  <= 1'b0;
			val_s6  <= 1'b0;
			val_s7  <= 1'b0;
			val_s8  <= 1'b0;
			val_s9  <= 1'b0;
			val_s10 <= 1'b0;
			val_s11 <= 1'b0;
		end else begin
			val_s3  <= dval_s[DIV_STAGES-1];
			val_s4  <= val_s3;
			val_s5  <= val_s4;
			val_s6  <= val_s5;
			val_s7  <= val_s6;
			val_s8  <= val_s7;
			val_s9  <= val_s8;
			val_s10 <= val_s9;
			val_s11 <= val_s10;
		end
	end

	// Advance payload.
	always_ff @(posedge clk) begin
		it_s3   <= it3_d;
		it_s4   <= it_s3;
		pvx_s4  <= it_s3.ax * $signed({1'b0, dt_q});
		pvy_s4  <= it_s3.ay * $signed({1'b0, dt_q});
		it_s5   <= it5_d;
		it_s6   <= it_s5;
		ppx_s6  <= it_s5.vx * $signed({1'b0, dt_q});
		ppy_s6  <= it_s5.vy * $signed({1'b0, dt_q});
		it_s7   <= it7_d;
		it_s8   <= it_s7;
		hx_s8   <= (longint'(it_s7.px) - radl) < -hwl;
		hy_s8   <= (longint'(it_s7.py) - radl) < -hhl;
		bpx_s8  <= absvx7 * BOUNCE_K;
		bpy_s8  <= absvy7 * BOUNCE_K;
		it_s9   <= it9_d;
		it_s10  <= it_s9;
		hx_s10  <= (longint'(it_s9.px) + radl) > hwl;
		hy_s10  <= (longint'(it_s9.py) + radl) > hhl;
		bpx_s10 <= absvx9 * BOUNCE_K;
		bpy_s10 <= absvy9 * BOUNCE_K;
		it_s11  <= it11_d;
	end

	// Drive result ports straight from the last stage.
	assign done             = val_s11;
	assign new_pos_x        = it_s11.px;
	assign new_pos_y        = it_s11.py;
	assign new_vel_x        = it_s11.vx;
	assign new_vel_y        = it_s11.vy;
	assign acc_x            = it_s11.ax;
	assign acc_y            = it_s11.ay;
	assign density_was_zero = it_s11.zero;
	assign wall_hits        = it_s11.hits;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("accepted word did not complete after fixed latency");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result strobe without an accepted word");

	a_stage_flow: assert property (@(posedge clk) disable iff (!arst_n)
		val_s7 |=> val_s8 ##3 done)
		else $error("valid bit lost between position and wall stages");

endmodule

// ===== tb/particle_euler_step_with_walls_top_tb.sv =====
// Self-checking testbench for particle_euler_step_with_walls_top.
// Depends on pew_pkg and the top level RTL; a scoreboard class predicts each
// particle step in 64-bit arithmetic and checks every done strobe in order.
module particle_euler_step_with_walls_top_tb import pew_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  LAT        = 23;
	localparam int  SETTLE     = LAT + 8;
	localparam int  MAX_CYCLES = 200000;
	localparam int  N_RANDOM   = 225;       // per configuration phase
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam longint ONE_Q   = 64'sd65536;
	localparam longint RHO_MIN = (ONE_Q + 5000) / 10000;
	localparam longint BOUNCE  = (ONE_Q * 16 + 5) / 10;

	// One particle as the block sees it on its input ports.
	typedef struct {
		logic signed [WORD_W-1:0] px, py, vx, vy;
		logic signed [WORD_W-1:0] pfx, pfy, vfx, vfy, sfx, sfy;
		logic [UWORD_W-1:0]       rho;
	} particle_t;

	// One step result as it leaves the block.
	typedef struct {
		logic signed [WORD_W-1:0] px, py, vx, vy, ax, ay;
		logic                     zero;
		logic [3:0]               hits;
	} step_t;

	class step_scoreboard;
		longint dt, gx, gy, mass, rad, hw, hh;
		step_t  pending[$];
		int     mismatches;

		function void reset_regs();
			dt = 655; gx = 0; gy = -642253; mass = 65536;
			rad = 6554; hw = 65536; hh = 65536;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [WORD_W-1:0] v);
			case (idx)
				REG_DT:   dt   = v[DT_W-1:0];
				REG_GX:   gx   = longint'(signed'(v));
				REG_GY:   gy   = longint'(signed'(v));
				REG_MASS: mass = v[UWORD_W-1:0];
				REG_RAD:  rad  = v[UWORD_W-1:0];
				REG_HW:   hw   = v[UWORD_W-1:0];
				REG_HH:   hh   = v[UWORD_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp32(longint v);
			return (v > S32_MAX) ? S32_MAX : (v < S32_MIN) ? S32_MIN : v;
		endfunction

		// Q16.16 product, floor rounding, saturated.
		function longint qmul(longint a, longint b);
			return clamp32((a * b) >>> 16);
		endfunction

		function longint accel(longint fsum, longint r, longint g);
			longint q;
			q = clamp32((fsum * ONE_Q) / r);
			return clamp32(q + qmul(g, mass));
		endfunction

		function longint bounce(longint v);
			return ((v < 0 ? -v : v) * BOUNCE) >>> 16;
		endfunction

		// Note an accepted particle: push the step it must produce.
		function void note(particle_t p);
			longint px, py, vx, vy, ax, ay, r;
			step_t  e;
			r = p.rho;
			e.zero = (r == 0);
			if (e.zero) r = RHO_MIN;
			ax = accel(longint'(p.pfx) + p.vfx + p.sfx, r, gx);
			ay = accel(longint'(p.pfy) + p.vfy + p.sfy, r, gy);
			vx = clamp32(p.vx + qmul(ax, dt));
			vy = clamp32(p.vy + qmul(ay, dt));
			px = clamp32(p.px + qmul(vx, dt));
			py = clamp32(p.py + qmul(vy, dt));
			e.hits = 4'b0;
			// walls in order left, right, bottom, top; later clamp wins
			if (px - rad < -hw) begin
				vx = clamp32(vx + bounce(vx)); px = rad - hw; e.hits[0] = 1'b1;
			end
			if (px + rad > hw) begin
				vx = clamp32(vx - bounce(vx)); px = hw - rad; e.hits[1] = 1'b1;
			end
			if (py - rad < -hh) begin
				vy = clamp32(vy + bounce(vy)); py = rad - hh; e.hits[2] = 1'b1;
			end
			if (py + rad > hh) begin
				vy = clamp32(vy - bounce(vy)); py = hh - rad; e.hits[3] = 1'b1;
			end
			e.px = WORD_W'(px); e.py = WORD_W'(py);
			e.vx = WORD_W'(vx); e.vy = WORD_W'(vy);
			e.ax = WORD_W'(ax); e.ay = WORD_W'(ay);
			pending.push_back(e);
		endfunction

		// Check a done word against the oldest expected step.
		function void check(step_t a);
			step_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
				return;
			end
			e = pending.pop_front();
			if (a.px !== e.px || a.py !== e.py || a.vx !== e.vx || a.vy !== e.vy ||
			    a.ax !== e.ax || a.ay !== e.ay || a.zero !== e.zero || a.hits !== e.hits) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch at %0t", $realtime);
					$display("  exp pos %0d %0d vel %0d %0d acc %0d %0d z %0b hits %b",
						e.px, e.py, e.vx, e.vy, e.ax, e.ay, e.zero, e.hits);
					$display("  got pos %0d %0d vel %0d %0d acc %0d %0d z %0b hits %b",
						a.px, a.py, a.vx, a.vy, a.ax, a.ay, a.zero, a.hits);
				end
			end
		endfunction
	endclass

	logic                     clk, arst_n, start, busy, cfg_we, done;
	logic signed [WORD_W-1:0] pos_x, pos_y, vel_x, vel_y;
	logic signed [WORD_W-1:0] pressure_fx, pressure_fy, viscous_fx, viscous_fy;
	logic signed [WORD_W-1:0] surface_fx, surface_fy;
	logic [UWORD_W-1:0]       rho;
	logic [CFG_IDX_W-1:0]     cfg_addr;
	logic [WORD_W-1:0]        cfg_data;
	logic signed [WORD_W-1:0] new_pos_x, new_pos_y, new_vel_x, new_vel_y, acc_x, acc_y;
	logic                     density_was_zero;
	logic [3:0]               wall_hits;

	step_scoreboard sb;
	int             cycles;
	bit             allow_gaps;

	particle_euler_step_with_walls_top i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung pipeline must not hang the run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("** particle_euler_step_with_walls_top: FAILED **");
			$finish;
		end
	end

	// Predict each accepted word and check each done strobe, both on the rising edge.
	always @(posedge clk) begin
		step_t     r;
		particle_t p;
		if (arst_n && start && !busy) begin
			p.px = pos_x; p.py = pos_y; p.vx = vel_x; p.vy = vel_y;
			p.pfx = pressure_fx; p.pfy = pressure_fy;
			p.vfx = viscous_fx; p.vfy = viscous_fy;
			p.sfx = surface_fx; p.sfy = surface_fy; p.rho = rho;
			sb.note(p);
		end
		if (arst_n && done) begin
			r.px = new_pos_x; r.py = new_pos_y; r.vx = new_vel_x; r.vy = new_vel_y;
			r.ax = acc_x; r.ay = acc_y; r.zero = density_was_zero; r.hits = wall_hits;
			sb.check(r);
		end
	end

	// Present one particle at the falling edge and hold it until taken.
	task automatic send(particle_t p);
		if (allow_gaps) begin
			while ($urandom_range(99) < 19) begin
				start = 1'b0;
				@(negedge clk);
			end
		end
		start = 1'b1;
		pos_x = p.px; pos_y = p.py; vel_x = p.vx; vel_y = p.vy;
		pressure_fx = p.pfx; pressure_fy = p.pfy;
		viscous_fx = p.vfx; viscous_fy = p.vfy;
		surface_fx = p.sfx; surface_fy = p.sfy; rho = p.rho;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Drop start and wait until every expected step has come back.
	task automatic drain();
		start = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Write one register; the pipeline is idle at this point.
	task automatic write_reg(cfg_reg_t idx, logic [WORD_W-1:0] v);
		cfg_we = 1'b1; cfg_addr = idx; cfg_data = v;
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Mostly physical magnitudes, with raw words and extremes mixed in.
	function automatic logic signed [WORD_W-1:0] pick_word(int span);
		case ($urandom_range(9))
			0:       return $urandom;
			1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			2:       return $signed($urandom_range(2 * 65536)) - 65536;
			default: return $signed($urandom_range(2 * span)) - span;
		endcase
	endfunction

	function automatic logic [UWORD_W-1:0] pick_rho();
		case ($urandom_range(7))
			0:       return '0;
			1:       return UWORD_W'($urandom);
			2:       return $urandom_range(1) ? 31'h7fffffff : 31'd1;
			default: return UWORD_W'($urandom_range(20 * 65536, 100));
		endcase
	endfunction

	function automatic particle_t random_particle();
		particle_t p;
		p.px  = pick_word(3 * 65536);  p.py  = pick_word(3 * 65536);
		p.vx  = pick_word(200 * 65536); p.vy  = pick_word(200 * 65536);
		p.pfx = pick_word(50 * 65536); p.pfy = pick_word(50 * 65536);
		p.vfx = pick_word(50 * 65536); p.vfy = pick_word(50 * 65536);
		p.sfx = pick_word(50 * 65536); p.sfy = pick_word(50 * 65536);
		p.rho = pick_rho();
		return p;
	endfunction

	function automatic particle_t uniform_particle(logic signed [WORD_W-1:0] w,
		logic [UWORD_W-1:0] r);
		particle_t p;
		p.px = w; p.py = w; p.vx = w; p.vy = w;
		p.pfx = w; p.pfy = w; p.vfx = w; p.vfy = w; p.sfx = w; p.sfy = w;
		p.rho = r;
		return p;
	endfunction

	task automatic random_phase();
		for (int i = 0; i < N_RANDOM; i++) begin
			// hold a long burst with no gaps in the middle of each phase
			allow_gaps = !(i >= 60 && i < 140);
			send(random_particle());
		end
		drain();
	endtask

	initial begin
		particle_t p;
		sb = new();
		sb.reset_regs();
		cycles = 0;
		allow_gaps = 1'b1;
		arst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_addr = REG_DT; cfg_data = '0;
		p = uniform_particle('0, '0);
		pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0;
		pressure_fx = 0; pressure_fy = 0; viscous_fx = 0; viscous_fy = 0;
		surface_fx = 0; surface_fy = 0; rho = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: field extremes, zero density, each wall alone and overlapping.
		send(uniform_particle('0, '0));
		send(uniform_particle(32'sh7fffffff, 31'h7fffffff));
		send(uniform_particle(32'sh80000000, 31'h7fffffff));
		send(uniform_particle(32'sh7fffffff, '0));
		send(uniform_particle(32'sh80000000, '0));
		send(uniform_particle(32'sh80000000, 31'd1));
		send(uniform_particle(-32'sd1, 31'd1));
		send(uniform_particle(32'sh55555555, 31'h2aaaaaaa));
		send(uniform_particle(32'shaaaaaaaa, 31'h55555555));
		for (int w = 0; w < 4; w++) begin
			p = uniform_particle('0, 31'd65536);
			p.vx = (w == 0) ? -32'sd655360 : (w == 1) ? 32'sd655360 : 0;
			p.vy = (w == 2) ? -32'sd655360 : (w == 3) ? 32'sd655360 : 0;
			p.px = (w == 0) ? -32'sd65000 : (w == 1) ? 32'sd65000 : 0;
			p.py = (w == 2) ? -32'sd65000 : (w == 3) ? 32'sd65000 : 0;
			send(p);
		end
		p = uniform_particle('0, 31'd65536);
		p.px = 32'sh7fffffff; p.py = 32'sh80000000; p.vx = 32'sh80000000;
		send(p);
		drain();

		random_phase();

		// Overlapping walls: radius beyond the half extents, at the extremes.
		write_reg(REG_RAD, 32'h7fffffff);
		write_reg(REG_HW, '0);
		write_reg(REG_HH, '0);
		write_reg(REG_DT, 32'd65536);
		random_phase();

		write_reg(REG_RAD, '0);
		write_reg(REG_HW, 32'h7fffffff);
		write_reg(REG_HH, 32'hffffffff);
		write_reg(REG_DT, '0);
		write_reg(REG_GX, 32'h7fffffff);
		write_reg(REG_GY, 32'h80000000);
		write_reg(REG_MASS, 32'h7fffffff);
		random_phase();

		write_reg(REG_MASS, '0);
		write_reg(REG_GX, 32'h80000000);
		write_reg(REG_GY, 32'h7fffffff);
		write_reg(REG_DT, 32'd1);
		random_phase();

		// Random moderate settings.
		write_reg(REG_DT, $urandom_range(65536));
		write_reg(REG_GX, $signed($urandom_range(40 * 65536)) - 20 * 65536);
		write_reg(REG_GY, $signed($urandom_range(40 * 65536)) - 20 * 65536);
		write_reg(REG_MASS, $urandom_range(4 * 65536));
		write_reg(REG_RAD, $urandom_range(65536));
		write_reg(REG_HW, $urandom_range(4 * 65536, 16384));
		write_reg(REG_HH, $urandom_range(4 * 65536, 16384));
		random_phase();

		write_reg(REG_DT, $urandom);
		write_reg(REG_GX, $urandom);
		write_reg(REG_GY, $urandom);
		write_reg(REG_MASS, $urandom);
		write_reg(REG_RAD, $urandom);
		write_reg(REG_HW, $urandom);
		write_reg(REG_HH, $urandom);
		random_phase();

		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("** particle_euler_step_with_walls_top: PASSED **");
		end else begin
			$display("** particle_euler_step_with_walls_top: FAILED **");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/pew_pkg.sv
design/pew_div.sv
design/particle_euler_step_with_walls_top.sv
tb/particle_euler_step_with_walls_top_tb.sv
